// ===== hdl/zero_crossing_frequency_estimator_macros.svh =====
// Assertion macros for the zero crossing frequency estimator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ZERO_CROSSING_FREQUENCY_ESTIMATOR_MACROS_SVH
`define ZERO_CROSSING_FREQUENCY_ESTIMATOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ZCFE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ZCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/zcfe_pkg.sv =====
// Shared types and constants of the zero crossing frequency estimator.
// No dependencies; imported by every module of the block.
package zcfe_pkg;

  localparam int unsigned RATE_W     = 20;
  localparam int unsigned FREQ_W     = 19;
  localparam int unsigned CNT_OUT_W  = 24;
  localparam int unsigned OUT_DATA_W = ((FREQ_W + 2 * CNT_OUT_W + 7) / 8) * 8;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd20000;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [FREQ_W-1:0] freq_t;

endpackage

// ===== hdl/zcfe_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on zcfe_pkg.
module zcfe_mul #(
  parameter int unsigned A_W = 24,
  parameter int unsigned B_W = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               busy_o,
  output logic [A_W+B_W-1:0] p_o
);
  import zcfe_pkg::*;

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [A_W-1:0]   a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [P_W-1:0]   p_q, p_d;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    if (start_i) begin
      cnt_d  = CNT_W'(B_W);
      busy_d = 1'b1;
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
    end else if (busy_q) begin
      p_d   = {p_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
      b_d   = {b_q[B_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      p_q    <= '0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      a_q    <= a_d;
      b_q    <= b_d;
      p_q    <= p_d;
    end
  end

  assign busy_o = busy_q;
  assign p_o    = p_q;

endmodule

// ===== hdl/zcfe_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// The quotient must fit in Q_W bits. Depends on zcfe_pkg.
module zcfe_div #(
  parameter int unsigned N_W = 44,
  parameter int unsigned D_W = 25,
  parameter int unsigned Q_W = 19
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] n_i,
  input  logic [D_W-1:0] d_i,
  output logic           busy_o,
  output logic [Q_W-1:0] q_o
);
  import zcfe_pkg::*;

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [D_W-1:0]   d_q, d_d;
  logic [D_W-1:0]   r_q, r_d;
  logic [Q_W-1:0]   l_q, l_d;
  logic [Q_W-1:0]   q_q, q_d;
  logic [D_W:0]     trial;

  assign trial = {r_q, l_q[Q_W-1]};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    d_d    = d_q;
    r_d    = r_q;
    l_d    = l_q;
    q_d    = q_q;
    if (start_i) begin
      cnt_d  = CNT_W'(Q_W);
      busy_d = 1'b1;
      d_d    = d_i;
      r_d    = D_W'(n_i >> Q_W);
      l_d    = n_i[Q_W-1:0];
      q_d    = '0;
    end else if (busy_q) begin
      l_d   = {l_q[Q_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, d_q}) begin
        r_d = D_W'(trial - {1'b0, d_q});
        q_d = {q_q[Q_W-2:0], 1'b1};
      end else begin
        r_d = D_W'(trial);
        q_d = {q_q[Q_W-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      d_q    <= '0;
      r_q    <= '0;
      l_q    <= '0;
      q_q    <= '0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      d_q    <= d_d;
      r_q    <= r_d;
      l_q    <= l_d;
      q_q    <= q_d;
    end
  end

  assign busy_o = busy_q;
  assign q_o    = q_q;

endmodule

// ===== hdl/zero_crossing_frequency_estimator.sv =====
// Zero crossing frequency estimator top level: state, sequencer, output register.
// Depends on zcfe_pkg, zcfe_mul, zcfe_div and the assertion macro header.
//
//   channel | direction | handshake            | content
//   s_axis  | in        | tvalid / tready      | tdata: sample; tuser: operation
//   m_axis  | out       | tvalid / tready      | tdata: freq, crossings, total; tuser: full
//   cfg     | in        | cfg_valid / cfg_ready| cfg_data: sample rate in Hz
//
// A sample item passes through S_MUL (the bit-serial rate and cls multipliers), S_ADJ,
// S_DIV (the 19-step divider) and S_OUT before the next item is accepted; a restart
// item goes from S_IDLE straight to S_OUT. Reset clears all sums and counts and loads
// the rate with 20000. An input item is taken while the last result waits on m_axis;
// the next result then holds the block until m_axis takes the last one.
module zero_crossing_frequency_estimator #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // sample [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata,
  // operation [0]
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // frequency_hz [18:0], crossing_count [42:19], sample_total [66:43], zero pad
  output logic [zcfe_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // count_full [0]
  output logic                                      m_axis_tuser,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [zcfe_pkg::RATE_W-1:0]               cfg_data_i
);
  import zcfe_pkg::*;

`include "zero_crossing_frequency_estimator_macros.svh"

  localparam int unsigned SUM_W  = COUNT_BITS + SAMPLE_BITS;
  localparam int unsigned PROD_W = COUNT_BITS + RATE_W;
  localparam int unsigned PAD_W  = OUT_DATA_W - FREQ_W - 2 * CNT_OUT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADJ,
    S_DIV,
    S_OUT
  } state_e;

  state_e                  state_q, state_d;
  rate_t                   rate_q, rate_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic                    flag_q, flag_d;
  logic [COUNT_BITS-1:0]   cross_q, cross_d;
  logic                    take_q, take_d;
  logic                    chg_q, chg_d;
  freq_t                   freq_q, freq_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]   m_data_q, m_data_d;
  logic                    m_user_q, m_user_d;

  logic                    accept;
  logic                    restart;
  logic                    full;
  logic [SAMPLE_BITS-1:0]  sample_w;
  logic                    cls_start;
  logic                    rate_start;
  logic                    cls_busy;
  logic                    rate_busy;
  logic [SUM_W-1:0]        cls_p;
  logic [PROD_W-1:0]       rate_p;
  logic                    cls;
  logic                    div_start;
  logic [PROD_W-1:0]       div_n;
  logic [COUNT_BITS:0]     div_d;
  logic                    div_busy;
  freq_t                   div_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = (op_e'(s_axis_tuser) == OP_RESTART);
  assign full          = (count_q == COUNT_LIMIT);
  assign sample_w      = s_axis_tdata[SAMPLE_BITS-1:0];
  assign cls_start     = accept && !restart && !full;
  assign rate_start    = accept && !restart;
  assign cls           = take_q ? (cls_p > sum_q) : flag_q;
  assign div_start     = (state_q == S_ADJ);
  assign div_n         = rate_p + (chg_q ? PROD_W'(rate_q) : '0);
  assign div_d         = {count_q, 1'b0};
  assign cfg_ready_o   = 1'b1;

  zcfe_mul #(
    .A_W (COUNT_BITS),
    .B_W (SAMPLE_BITS)
  ) u_cls_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cls_start),
    .a_i     (count_q + 1'b1),
    .b_i     (sample_w),
    .busy_o  (cls_busy),
    .p_o     (cls_p)
  );

  zcfe_mul #(
    .A_W (COUNT_BITS),
    .B_W (RATE_W)
  ) u_rate_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rate_start),
    .a_i     (cross_q),
    .b_i     (rate_q),
    .busy_o  (rate_busy),
    .p_o     (rate_p)
  );

  zcfe_div #(
    .N_W (PROD_W),
    .D_W (COUNT_BITS + 1),
    .Q_W (FREQ_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  always_comb begin
    state_d   = state_q;
    rate_d    = rate_q;
    sum_d     = sum_q;
    count_d   = count_q;
    flag_d    = flag_q;
    cross_d   = cross_q;
    take_d    = take_q;
    chg_d     = chg_q;
    freq_d    = freq_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    if (cfg_valid_i) begin
      rate_d = cfg_data_i;
    end
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (restart) begin
            sum_d   = '0;
            count_d = '0;
            flag_d  = 1'b0;
            cross_d = '0;
            freq_d  = '0;
            state_d = S_OUT;
          end else begin
            take_d = !full;
            if (!full) begin
              sum_d   = sum_q + SUM_W'(sample_w);
              count_d = count_q + 1'b1;
            end
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (!cls_busy && !rate_busy) begin
          flag_d = cls;
          chg_d  = (cls != flag_q);
          if (cls != flag_q) begin
            cross_d = cross_q + 1'b1;
          end
          state_d = S_ADJ;
        end
      end
      S_ADJ: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          freq_d  = div_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, CNT_OUT_W'(count_q), CNT_OUT_W'(cross_q), freq_q};
          m_user_d  = full;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rate_q    <= RATE_RESET;
      sum_q     <= '0;
      count_q   <= '0;
      flag_q    <= 1'b0;
      cross_q   <= '0;
      take_q    <= 1'b0;
      chg_q     <= 1'b0;
      freq_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rate_q    <= rate_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      flag_q    <= flag_d;
      cross_q   <= cross_d;
      take_q    <= take_d;
      chg_q     <= chg_d;
      freq_q    <= freq_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `ZCFE_ASSERT_NEXT(a_one_item_at_a_time, clk_i, rst_ni, accept, !s_axis_tready, "item accepted while busy")
  `ZCFE_ASSERT_ALWAYS(a_crossings_bounded, clk_i, rst_ni, cross_q <= count_q, "crossings exceed samples")
  `ZCFE_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, full && !(accept && restart), count_q == COUNT_LIMIT, "count left its limit")

endmodule
